>>> hw/rtl/lr1d_pkg.sv
// Package with shared constants and types of the linear resampler.
`default_nettype none

package lr1d_pkg;

  // Default sizes of the sample store.
  localparam int MAX_POINTS_DEF   = 1024;
  localparam int MAX_CHANNELS_DEF = 4;

  // Depth of the queue between the front and the back end.
  localparam int QUEUE_DEPTH = 4;

  // Item kinds carried in tuser.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OLD_COUNT     = 2'd0;
  localparam logic [1:0] CFG_NEW_COUNT     = 2'd1;
  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;
  localparam logic [1:0] CFG_STEP_RATIO    = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [10:0] OLD_COUNT_RST     = 11'd2;
  localparam logic [15:0] NEW_COUNT_RST     = 16'd2;
  localparam logic [2:0]  CHANNEL_COUNT_RST = 3'd1;
  localparam logic [31:0] STEP_RATIO_RST    = 32'h0001_0000;

  typedef struct packed {
    logic [10:0] old_count;
    logic [15:0] new_count;
    logic [2:0]  channel_count;
    logic [31:0] step_ratio;
  } lr1d_cfg_t;

  // One decoded command on its way from the front to the back end.
  // Index fields are wide enough for the largest store the design allows.
  typedef struct packed {
    logic        is_load;
    logic [1:0]  ch;
    logic [15:0] point;
    logic [15:0] lo_idx;
    logic [15:0] hi_idx;
    logic [15:0] frac;
    logic [31:0] value;
  } lr1d_entry_t;

  // Sideband that follows a result through the back-end pipeline.
  typedef struct packed {
    logic        valid;
    logic [1:0]  ch;
    logic [15:0] point;
    logic        last;
  } lr1d_tag_t;

endpackage

`default_nettype wire

>>> hw/rtl/linear_resampler_1d.sv
// Top level of the one-dimensional linear-interpolation resampler.
//
// Channel  Direction  Handshake           Carries
// s_*      in         s_tvalid/s_tready   sample loads and grid point queries
// m_*      out        m_tvalid/m_tready   one interpolated value per channel
// cfg_*    in         cfg_valid/cfg_ready configuration register writes
//
// The front end finishes each item before it takes the next, a load through its
// push state and a query through its multiply and push states; the back end writes
// a load into the sample store and serves a query one channel per cycle while the
// output is not stalled, through the two read ports of the sample store. Reset
// restores the configuration defaults and empties the queue; store contents are
// undefined until written, with no clearing pass. A low m_tready freezes the
// back-end pipeline while the four-entry queue lets the front end keep accepting.
`default_nettype none

module linear_resampler_1d #(
  parameter int MAX_POINTS   = lr1d_pkg::MAX_POINTS_DEF,
  parameter int MAX_CHANNELS = lr1d_pkg::MAX_CHANNELS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  // Input stream.
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [55:0] s_tdata,   // channel_sel[1:0], point_index[17:2], sample_value[49:18]
  input  wire         s_tuser,   // kind
  // Output stream.
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [55:0] m_tdata,   // out_channel[1:0], out_point[17:2], interp_value[49:18]
  output logic        m_tlast,   // last_of_point
  // Configuration writes.
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  import lr1d_pkg::*;

  lr1d_cfg_t   cfg;
  lr1d_entry_t q_in;
  lr1d_entry_t q_head;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  logic [1:0]  out_channel;
  logic [15:0] out_point;
  logic [31:0] out_value;

  // Configuration registers accept a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.old_count     <= OLD_COUNT_RST;
      cfg.new_count     <= NEW_COUNT_RST;
      cfg.channel_count <= CHANNEL_COUNT_RST;
      cfg.step_ratio    <= STEP_RATIO_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OLD_COUNT:     cfg.old_count     <= cfg_data[10:0];
        CFG_NEW_COUNT:     cfg.new_count     <= cfg_data[15:0];
        CFG_CHANNEL_COUNT: cfg.channel_count <= cfg_data[2:0];
        CFG_STEP_RATIO:    cfg.step_ratio    <= cfg_data;
        default:           cfg.step_ratio    <= cfg.step_ratio;
      endcase
    end
  end

  // The front end decodes each query into a queue entry holding the saturated
  // point, both clamped neighbour indexes and the blend fraction; loads outside the store are dropped.
  lr1d_front #(
    .MAX_POINTS   (MAX_POINTS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_kind  (s_tuser),
    .in_ch    (s_tdata[1:0]),
    .in_point (s_tdata[17:2]),
    .in_value (s_tdata[49:18]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  lr1d_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  // The back end owns the sample store, so loads and queries stay in order.
  lr1d_back #(
    .MAX_POINTS   (MAX_POINTS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (q_head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_channel (out_channel),
    .out_point   (out_point),
    .out_value   (out_value),
    .out_last    (m_tlast)
  );

  assign m_tdata = {6'd0, out_value, out_point, out_channel};

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue push while full");

  // The back end never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue pop while empty");

  // With a single channel every result is channel zero and closes its query.
  a_single_channel: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && cfg.channel_count == 3'd1) |-> (m_tlast && m_tdata[1:0] == 2'd0))
    else $error("single-channel result misframed");

endmodule

`default_nettype wire

>>> hw/rtl/lr1d_front.sv
// Front end: accepts items, saturates the query point and works out neighbours.
`default_nettype none

module lr1d_front #(
  parameter int MAX_POINTS   = lr1d_pkg::MAX_POINTS_DEF,
  parameter int MAX_CHANNELS = lr1d_pkg::MAX_CHANNELS_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  lr1d_pkg::lr1d_cfg_t     cfg,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire                     in_kind,
  input  wire  [1:0]              in_ch,
  input  wire  [15:0]             in_point,
  input  wire  [31:0]             in_value,
  input  wire                     q_full,
  output logic                    q_push,
  output lr1d_pkg::lr1d_entry_t   q_entry
);
  import lr1d_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_t;

  fstate_t     state;
  logic        kind_r;
  logic [1:0]  ch_r;
  logic [15:0] pt_r;
  logic [15:0] p_r;
  logic [31:0] value_r;
  logic [47:0] y_r;

  logic [15:0] last_new;
  logic [15:0] p_sat;
  logic [16:0] oc17;
  logic [15:0] last_old;
  logic [31:0] lo32;
  logic [32:0] hi33;
  logic        load_ok;
  logic        keep;

  // Last point of the new grid; a count of zero behaves as one.
  assign last_new = (cfg.new_count == 16'd0) ? 16'd0 : cfg.new_count - 16'd1;
  assign p_sat    = (in_point > last_new) ? last_new : in_point;

  // Old grid size clamped to the store.
  always_comb begin
    if (cfg.old_count == 11'd0) begin
      oc17 = 17'd1;
    end else if ({6'd0, cfg.old_count} > 17'(MAX_POINTS)) begin
      oc17 = 17'(MAX_POINTS);
    end else begin
      oc17 = {6'd0, cfg.old_count};
    end
  end
  assign last_old = 16'(oc17 - 17'd1);

  assign lo32 = y_r[47:16];
  assign hi33 = {1'b0, lo32} + 33'd1;

  assign load_ok = ({3'd0, ch_r} < 5'(MAX_CHANNELS)) && ({1'b0, pt_r} < 17'(MAX_POINTS));
  assign keep    = (kind_r == KIND_QUERY) || load_ok;

  assign in_ready = (state == F_IDLE);
  assign q_push   = (state == F_PUSH) && keep && !q_full;

  always_comb begin
    q_entry = '0;
    if (kind_r == KIND_LOAD) begin
      q_entry.is_load = 1'b1;
      q_entry.ch      = ch_r;
      q_entry.point   = pt_r;
      q_entry.value   = value_r;
    end else begin
      q_entry.point = p_r;
      if (p_r == 16'd0) begin
        q_entry.lo_idx = 16'd0;
        q_entry.hi_idx = 16'd0;
      end else if (p_r == last_new) begin
        q_entry.lo_idx = last_old;
        q_entry.hi_idx = last_old;
      end else begin
        q_entry.frac   = y_r[15:0];
        q_entry.lo_idx = (lo32 > {16'd0, last_old}) ? last_old : lo32[15:0];
        q_entry.hi_idx = (hi33 > {17'd0, last_old}) ? last_old : hi33[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            state <= (in_kind == KIND_QUERY) ? F_MUL : F_PUSH;
          end
        end
        F_MUL: begin
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!keep || !q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      kind_r  <= in_kind;
      ch_r    <= in_ch;
      pt_r    <= in_point;
      p_r     <= p_sat;
      value_r <= in_value;
    end
    if (state == F_MUL) begin
      y_r <= {32'd0, p_r} * {16'd0, cfg.step_ratio};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lr1d_fifo.sv
// Short command queue between the front and the back end.
`default_nettype none

module lr1d_fifo (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     push,
  input  lr1d_pkg::lr1d_entry_t   push_entry,
  output logic                    full,
  input  wire                     pop,
  output lr1d_pkg::lr1d_entry_t   head,
  output logic                    empty
);
  import lr1d_pkg::*;

  localparam int QP_W = $clog2(QUEUE_DEPTH);

  lr1d_entry_t       slots [QUEUE_DEPTH];
  logic [QP_W-1:0]   wr_ptr;
  logic [QP_W-1:0]   rd_ptr;
  logic [QP_W:0]     count;

  assign full  = (count == (QP_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lr1d_back.sv
// Back end: sample store, per-channel read sequencer and blend pipeline.
`default_nettype none

module lr1d_back #(
  parameter int MAX_POINTS   = lr1d_pkg::MAX_POINTS_DEF,
  parameter int MAX_CHANNELS = lr1d_pkg::MAX_CHANNELS_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  lr1d_pkg::lr1d_cfg_t     cfg,
  input  lr1d_pkg::lr1d_entry_t   head,
  input  wire                     q_empty,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [1:0]              out_channel,
  output logic [15:0]             out_point,
  output logic [31:0]             out_value,
  output logic                    out_last
);
  import lr1d_pkg::*;

  localparam int DEPTH = MAX_CHANNELS * MAX_POINTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PT_W  = $clog2(MAX_POINTS);

  logic [31:0]   store [DEPTH];

  lr1d_entry_t   cur;
  logic          busy;
  logic [2:0]    j;
  logic [2:0]    ccm1;
  logic          adv;
  logic          issue_last;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;

  lr1d_tag_t          tag1, tag2, tag3;
  logic [15:0]        frac1, frac2;
  logic [31:0]        rd_a, rd_b, a2, a3;
  logic signed [32:0] diff2;
  logic signed [49:0] prod3;
  logic signed [16:0] frac_s;

  // Channels in use, clamped to the store, minus one.
  always_comb begin
    if (cfg.channel_count == 3'd0) begin
      ccm1 = 3'd0;
    end else if ({2'd0, cfg.channel_count} > 5'(MAX_CHANNELS)) begin
      ccm1 = 3'(MAX_CHANNELS - 1);
    end else begin
      ccm1 = cfg.channel_count - 3'd1;
    end
  end

  assign adv        = !out_valid || out_ready;
  assign issue_last = busy && (j == ccm1);
  assign q_pop      = adv && !q_empty && (!busy || issue_last);
  assign wr_en      = q_pop && head.is_load;
  assign wr_addr    = AW'(head.ch) * AW'(MAX_POINTS) + AW'(head.point[PT_W-1:0]);
  assign addr_a     = AW'(j) * AW'(MAX_POINTS) + AW'(cur.lo_idx[PT_W-1:0]);
  assign addr_b     = AW'(j) * AW'(MAX_POINTS) + AW'(cur.hi_idx[PT_W-1:0]);
  assign frac_s     = signed'({1'b0, frac2});

  // Sequencer: one channel per cycle while the output is not stalled, next command taken on the last channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      j    <= '0;
    end else if (adv) begin
      if (q_pop && !head.is_load) begin
        busy <= 1'b1;
        j    <= '0;
      end else if (issue_last) begin
        busy <= 1'b0;
      end else if (busy) begin
        j <= j + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !head.is_load) begin
      cur <= head;
    end
  end

  // Sample store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= head.value;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_a <= store[addr_a];
      rd_b <= store[addr_b];
    end
  end

  // Blend pipeline: v = lo + ((frac * (hi - lo)) >>> 16). Only the valid bits
  // are cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid <= 1'b0;
      tag2.valid <= 1'b0;
      tag3.valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (adv) begin
      tag1.valid <= busy;
      tag2.valid <= tag1.valid;
      tag3.valid <= tag2.valid;
      out_valid  <= tag3.valid;

      tag1.ch    <= j[1:0];
      tag1.point <= cur.point;
      tag1.last  <= issue_last;
      frac1      <= cur.frac;

      tag2.ch    <= tag1.ch;
      tag2.point <= tag1.point;
      tag2.last  <= tag1.last;
      frac2      <= frac1;
      a2         <= rd_a;
      diff2      <= signed'({rd_b[31], rd_b}) - signed'({rd_a[31], rd_a});

      tag3.ch    <= tag2.ch;
      tag3.point <= tag2.point;
      tag3.last  <= tag2.last;
      a3         <= a2;
      prod3      <= frac_s * diff2;

      out_channel <= tag3.ch;
      out_point   <= tag3.point;
      out_last    <= tag3.last;
      out_value   <= a3 + prod3[47:16];
    end
  end

endmodule

`default_nettype wire
